FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

FILE: rtl/core/oqp_pkg.sv
//------------------------------------------------------------------------------
// oqp_pkg
// Shared types and constants for the operation queue with purge.
//------------------------------------------------------------------------------
package oqp_pkg;

	localparam int QueueDepthDef = 16;
	localparam int NumPoolsDef   = 4;
	localparam int PoolSlotsDef  = 8;
	localparam int MaxDropReports = 16;

	localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [2:0] CMD_POP        = 3'd2;
	localparam logic [2:0] CMD_RELEASE    = 3'd3;
	localparam logic [2:0] CMD_PURGE      = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ERR  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	localparam logic [31:0] ID_INIT     = 32'd10;
	localparam logic [31:0] ID_KILL     = 32'd11;
	localparam logic [31:0] ID_START    = 32'd12;
	localparam logic [31:0] ID_SHUTDOWN = 32'd14;
	localparam logic [3:0]  KIND_RR_RECEIVED = 4'd1;
	localparam logic [1:0]  MS_IDLE  = 2'd0;
	localparam logic [1:0]  MS_READY = 2'd1;

	localparam logic [1:0] REG_LIMIT0 = 2'd0;

	// queue entry
	typedef struct packed {
		logic [1:0]  pool;
		logic        act;
		logic [3:0]  kind;
		logic [31:0] op_id;
		logic [15:0] module_id;
		logic [7:0]  len;
		logic [31:0] word;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic push_back;
		logic push_front;
		logic pop;
		logic release_slot;
		logic purge_start;
		logic walk_rd;
		logic walk_step;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic push_ok;
		logic pop_wait;
		logic pop_empty;
		logic rel_ok;
		logic walk_done;
		logic walk_report;
	} dp_stat_t;

endpackage

FILE: rtl/core/oqp_datapath.sv
//------------------------------------------------------------------------------
// oqp_datapath
// Entry memory, pointers, counters, pool budget and purge walk.
//------------------------------------------------------------------------------
module oqp_datapath import oqp_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepthDef,
	parameter int NUM_POOLS   = NumPoolsDef,
	parameter int POOL_SLOTS  = PoolSlotsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [3:0]  pool_index,
	input  logic [31:0] op_id,
	input  logic [3:0]  op_kind,
	input  logic        activating,
	input  logic [7:0]  param_len,
	input  logic [31:0] param_word,
	input  logic [15:0] module_id,
	input  logic [1:0]  module_state,
	input  logic [7:0]  limit [4],
	output entry_t      rd_entry,
	output logic [4:0]  rep_cnt
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = $clog2(POOL_SLOTS + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(QUEUE_DEPTH - 1);

	entry_t mem_q [QUEUE_DEPTH];
	logic [PW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q, walk_left_q;
	// start entries counted by a purge stay counted after their pop,
	// so the activating count can reach twice the depth
	logic [CW:0]   act_q;
	logic [SW-1:0] free_q [4];
	logic          start_seen_q;
	logic [1:0]    mstate_q;
	logic [4:0]    rep_q;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction
	function automatic logic [PW-1:0] prv(input logic [PW-1:0] i);
		return (i == '0) ? LAST_IDX : i - 1'b1;
	endfunction

	// push checks and entry build
	logic          pool_ok;
	logic [1:0]    pl;
	logic [7:0]    clen;
	logic [31:0]   cword;
	entry_t        new_e;
	assign pl      = pool_index[1:0];
	assign pool_ok = ({28'd0, pool_index} < 32'(NUM_POOLS));
	always_comb begin
		clen  = (param_len > limit[pl]) ? limit[pl] : param_len;
		cword = param_word;
		case (clen)
			8'd0: cword = '0;
			8'd1: cword = {24'd0, param_word[7:0]};
			8'd2: cword = {16'd0, param_word[15:0]};
			8'd3: cword = {8'd0, param_word[23:0]};
			default: cword = param_word;
		endcase
		new_e = '{pool: pl, act: activating, kind: op_kind, op_id: op_id,
			module_id: module_id, len: clen, word: cword};
	end

	assign stat.push_ok   = pool_ok && (free_q[pl] != '0) && (count_q < CW'(QUEUE_DEPTH));
	assign stat.pop_wait  = (act_q == '0);
	assign stat.pop_empty = (count_q == '0);
	assign stat.rel_ok    = pool_ok;
	assign stat.walk_done = (walk_left_q == '0);
	assign rep_cnt = rep_q;

	// registered memory read at head
	always_ff @(posedge clk) begin
		rd_entry <= mem_q[head_q];
	end

	// purge decision on the entry read out
	logic keep, cnt_act;
	always_comb begin
		keep = 1'b0; cnt_act = 1'b0;
		if (rd_entry.op_id == ID_START && mstate_q == MS_READY) begin
			keep = 1'b1; cnt_act = 1'b1;
		end else if (start_seen_q || rd_entry.op_id == ID_KILL ||
			(rd_entry.op_id == ID_SHUTDOWN && mstate_q != MS_IDLE) ||
			(rd_entry.op_id == ID_INIT && mstate_q == MS_IDLE)) begin
			keep = 1'b1; cnt_act = rd_entry.act;
		end
	end
	assign stat.walk_report = !keep && rd_entry.kind == KIND_RR_RECEIVED &&
		rep_q < 5'(MaxDropReports);

	// memory write
	always_ff @(posedge clk) begin
		if (cmd.push_back && stat.push_ok) mem_q[tail_q] <= new_e;
		else if (cmd.push_front && stat.push_ok) mem_q[prv(head_q)] <= new_e;
		else if (cmd.walk_step && keep) mem_q[tail_q] <= rd_entry;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0; tail_q <= '0; count_q <= '0; act_q <= '0;
			walk_left_q <= '0; start_seen_q <= 1'b0; mstate_q <= '0; rep_q <= '0;
			for (int i = 0; i < 4; i++) free_q[i] <= SW'(POOL_SLOTS);
		end else begin
			if ((cmd.push_back || cmd.push_front) && stat.push_ok) begin
				if (cmd.push_back) tail_q <= nxt(tail_q);
				else head_q <= prv(head_q);
				count_q <= count_q + 1'b1;
				if (activating) act_q <= act_q + 1'b1;
				free_q[pl] <= free_q[pl] - 1'b1;
			end
			if (cmd.pop && !stat.pop_wait && !stat.pop_empty) begin
				head_q <= nxt(head_q);
				count_q <= count_q - 1'b1;
				if (rd_entry.act) act_q <= act_q - 1'b1;
			end
			if (cmd.release_slot && pool_ok && free_q[pl] < SW'(POOL_SLOTS))
				free_q[pl] <= free_q[pl] + 1'b1;
			if (cmd.purge_start) begin
				walk_left_q <= count_q;
				act_q <= '0;
				start_seen_q <= 1'b0;
				mstate_q <= module_state;
				rep_q <= '0;
			end
			if (cmd.walk_step) begin
				walk_left_q <= walk_left_q - 1'b1;
				head_q <= nxt(head_q);
				if (keep) begin
					tail_q <= nxt(tail_q);
					if (cnt_act) act_q <= act_q + 1'b1;
					if (rd_entry.op_id == ID_START && mstate_q == MS_READY)
						start_seen_q <= 1'b1;
				end else begin
					count_q <= count_q - 1'b1;
					if (free_q[rd_entry.pool] < SW'(POOL_SLOTS) &&
						{30'd0, rd_entry.pool} < 32'(NUM_POOLS))
						free_q[rd_entry.pool] <= free_q[rd_entry.pool] + 1'b1;
					if (stat.walk_report) rep_q <= rep_q + 1'b1;
				end
			end
		end
	end

	logic unused;
	assign unused = cmd.walk_rd;

endmodule

FILE: rtl/core/oqp_ctrl.sv
//------------------------------------------------------------------------------
// oqp_ctrl
// Command sequencer and result register.
//------------------------------------------------------------------------------
module oqp_ctrl import oqp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	output logic        out_valid,
	input  logic        out_ready,
	output dp_cmd_t     dcmd,
	input  dp_stat_t    stat,
	input  entry_t      rd_entry,
	output logic [1:0]  status,
	output entry_t      out_e,
	output logic        dropped_request_valid,
	output logic [31:0] dropped_request_id,
	output logic        last
);

	typedef enum logic [2:0] {S_IDLE, S_POP, S_WREAD, S_WALK, S_WOUT, S_FIN} state_t;
	state_t state_q;

	logic acc, free_out;
	assign free_out = !out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE) && free_out;
	assign acc = in_valid && in_ready;

	// commands decoded from state and the accepted request
	always_comb begin
		dcmd = '0;
		dcmd.push_back    = acc && cmd == CMD_PUSH_BACK;
		dcmd.push_front   = acc && cmd == CMD_PUSH_FRONT;
		dcmd.release_slot = acc && cmd == CMD_RELEASE;
		dcmd.purge_start  = acc && cmd == CMD_PURGE;
		dcmd.pop          = state_q == S_POP;
		dcmd.walk_rd      = state_q == S_WREAD;
		dcmd.walk_step    = state_q == S_WALK && (!stat.walk_report || free_out);
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			status <= ST_OK; out_e <= '0; dropped_request_valid <= 1'b0;
			dropped_request_id <= '0; last <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (acc) begin
					out_e <= '0; dropped_request_valid <= 1'b0;
					dropped_request_id <= '0; last <= 1'b1;
					case (cmd)
						CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
							status <= stat.push_ok ? ST_OK : ST_ERR;
							out_valid <= 1'b1;
						end
						CMD_RELEASE: begin
							status <= stat.rel_ok ? ST_OK : ST_ERR;
							out_valid <= 1'b1;
						end
						CMD_POP:   state_q <= S_POP;
						CMD_PURGE: state_q <= S_WREAD;
						default: begin
							status <= ST_ERR;
							out_valid <= 1'b1;
						end
					endcase
				end
				S_POP: begin
					last <= 1'b1; out_valid <= 1'b1; state_q <= S_IDLE;
					if (stat.pop_wait) status <= ST_WAIT;
					else if (stat.pop_empty) status <= ST_ERR;
					else begin
						status <= ST_OK; out_e <= rd_entry;
					end
				end
				S_WREAD: state_q <= stat.walk_done ? S_FIN : S_WALK;
				S_WALK: if (dcmd.walk_step) begin
					if (stat.walk_report) begin
						status <= ST_OK; out_e <= '0; last <= 1'b0;
						dropped_request_valid <= 1'b1;
						dropped_request_id <= rd_entry.word;
						out_valid <= 1'b1;
					end
					state_q <= S_WOUT;
				end
				S_WOUT: state_q <= S_WREAD;
				S_FIN: if (free_out) begin
					status <= ST_OK; out_e <= '0; last <= 1'b1;
					dropped_request_valid <= 1'b0; dropped_request_id <= '0;
					out_valid <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/operation_queue_with_purge.sv
//------------------------------------------------------------------------------
// operation_queue_with_purge
// Deque of operation descriptors with pool budget, pop gating and purge.
//------------------------------------------------------------------------------
// channel | direction | handshake
// in      | input     | in_valid / in_ready
// out     | output    | out_valid / out_ready
// cfg     | input     | cfg_we (no wait)
// Push, release, unknown: registered on acceptance. Pop: S_POP, registered read.
// Purge: S_WREAD, S_WALK, S_WOUT per entry walked, then S_WREAD and S_FIN.
// A stalled result holds the block; reset clears pointers, counts and pools.
//------------------------------------------------------------------------------
`include "assert_macros.svh"
module operation_queue_with_purge import oqp_pkg::*; #(
	parameter int QUEUE_DEPTH = QueueDepthDef,
	parameter int NUM_POOLS   = NumPoolsDef,
	parameter int POOL_SLOTS  = PoolSlotsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [3:0]  pool_index,
	input  logic [31:0] op_id,
	input  logic [3:0]  op_kind,
	input  logic        activating,
	input  logic [7:0]  param_len,
	input  logic [31:0] param_word,
	input  logic [15:0] module_id,
	input  logic [1:0]  module_state,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] out_op_id,
	output logic [3:0]  out_op_kind,
	output logic        out_activating,
	output logic [7:0]  out_param_len,
	output logic [31:0] out_param_word,
	output logic [15:0] out_module_id,
	output logic [1:0]  out_pool,
	output logic        dropped_request_valid,
	output logic [31:0] dropped_request_id,
	output logic        last
);

	logic [7:0] limit_q [4];
	dp_cmd_t    dcmd;
	dp_stat_t   stat;
	entry_t     rd_entry, out_e;
	logic [4:0] rep_cnt;

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) limit_q[i] <= 8'hFF;
		end else if (cfg_we) begin
			limit_q[cfg_index - REG_LIMIT0] <= cfg_data;
		end
	end

	oqp_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .NUM_POOLS(NUM_POOLS),
		.POOL_SLOTS(POOL_SLOTS)) u_dp (
		.clk, .arst_n, .cmd(dcmd), .stat, .pool_index, .op_id, .op_kind,
		.activating, .param_len, .param_word, .module_id, .module_state,
		.limit(limit_q), .rd_entry, .rep_cnt
	);

	oqp_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .cmd, .out_valid, .out_ready,
		.dcmd, .stat, .rd_entry, .status, .out_e, .dropped_request_valid,
		.dropped_request_id, .last
	);

	assign out_op_id      = out_e.op_id;
	assign out_op_kind    = out_e.kind;
	assign out_activating = out_e.act;
	assign out_param_len  = out_e.len;
	assign out_param_word = out_e.word;
	assign out_module_id  = out_e.module_id;
	assign out_pool       = out_e.pool;

	`ASSERT_NEVER(a_rep_bound, clk, arst_n, rep_cnt > 5'(MaxDropReports), "report overflow")
	`ASSERT_IMPL(a_drop_not_last, clk, arst_n, out_valid && dropped_request_valid |-> !last, "drop marked last")
	`ASSERT_IMPL(a_wait_no_data, clk, arst_n, out_valid && status == ST_WAIT |-> out_op_id == '0, "wait with data")

endmodule
